// ===== src/fla_pkg.sv =====
`default_nettype none

package fla_pkg;

   // field widths fixed by the interface
   localparam int ENTRY_W = 10;
   localparam int ACT_W   = 2;
   localparam int STS_W   = 2;

   // action codes (code 3 is unused and answers ok with no state change)
   localparam logic [ACT_W-1:0] ACT_TAKE    = 2'd0;
   localparam logic [ACT_W-1:0] ACT_RETURN  = 2'd1;
   localparam logic [ACT_W-1:0] ACT_RESERVE = 2'd2;

   // status codes
   localparam logic [STS_W-1:0] STS_OK   = 2'd0;
   localparam logic [STS_W-1:0] STS_FULL = 2'd1;
   localparam logic [STS_W-1:0] STS_BAD  = 2'd2;

   // controller to datapath commands
   typedef struct packed {
      logic load_req;   // capture the request, start the link read
      logic execute;    // commit the state update, load the result register
   } ctl_cmd_type;

endpackage

`default_nettype wire

// ===== src/free_list_entry_allocator_top.sv =====
`default_nettype none

// channel  dir  tdata (low bit up)                       tuser
// req      in   entry_in[9:0], run_length[19:10], 0 pad   action[1:0]
// rsp      out  entry_out[9:0], status[11:10], 0 pad      -
//
// Each request is accepted, then the link memory read at the free-list head
// comes back registered and the state update commits.
// One request is in flight at a time; the result register lets the next
// request be accepted while a result waits for its transfer.
// reset is synchronous: free list empty, bump pointer at 1. The link memory
// is not cleared; only returned entries are ever read back.
module free_list_entry_allocator_top #(
   parameter int DEPTH = 1024
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [23:0] req_tdata,   // entry_in[9:0], run_length[19:10]
   input  wire  [1:0]  req_tuser,   // action[1:0]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [15:0] rsp_tdata    // entry_out[9:0], status[11:10]
);
   import fla_pkg::*;

   ctl_cmd_type        cmd;
   logic [ENTRY_W-1:0] rsp_entry;
   logic [STS_W-1:0]   rsp_status;

   fla_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   fla_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_action (req_tuser[ACT_W-1:0]),
      .req_entry  (req_tdata[ENTRY_W-1:0]),
      .req_count  (req_tdata[2*ENTRY_W-1:ENTRY_W]),
      .rsp_entry  (rsp_entry),
      .rsp_status (rsp_status)
   );

   assign rsp_tdata = {4'b0000, rsp_status, rsp_entry};

endmodule

`default_nettype wire

// ===== src/fla_ctrl.sv =====
`default_nettype none

module fla_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  wire                  rsp_tready,
   output fla_pkg::ctl_cmd_type cmd
);
   import fla_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      req_tready   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = S_EXEC;
            end
         end
         S_EXEC: begin
            // wait for the result register to drain before committing
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.execute  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

`ifndef NO_ASSERTIONS
   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == S_EXEC))
      else $error("accepted request did not enter execute");

   a_exec_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register overwritten before transfer");

   a_exec_gives_result: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |=> (rsp_tvalid && state_ff == S_IDLE))
      else $error("execute did not present a result");
`endif

endmodule

`default_nettype wire

// ===== src/fla_dp.sv =====
`default_nettype none

module fla_dp #(
   parameter int DEPTH = 1024
) (
   input  wire                          clock,
   input  wire                          reset,
   input  fla_pkg::ctl_cmd_type         cmd,
   input  wire [fla_pkg::ACT_W-1:0]     req_action,
   input  wire [fla_pkg::ENTRY_W-1:0]   req_entry,
   input  wire [fla_pkg::ENTRY_W-1:0]   req_count,
   output logic [fla_pkg::ENTRY_W-1:0]  rsp_entry,
   output logic [fla_pkg::STS_W-1:0]    rsp_status
);
   import fla_pkg::*;

   localparam int BW    = $clog2(DEPTH + 1);
   localparam int CW    = ((BW > ENTRY_W) ? BW : ENTRY_W) + 1;
   // only indices that fit the entry field are ever returned and linked
   localparam int LDEPTH = (DEPTH < (1 << ENTRY_W)) ? DEPTH : (1 << ENTRY_W);
   localparam int LAW    = $clog2(LDEPTH);

   logic [ENTRY_W-1:0] link_mem [LDEPTH];
   logic [ENTRY_W-1:0] link_rd_ff;

   logic [ACT_W-1:0]   act_ff;
   logic [ENTRY_W-1:0] entry_ff;
   logic [ENTRY_W-1:0] count_ff;

   logic [ENTRY_W-1:0] head_ff, head_in;
   logic [BW-1:0]      bump_ff, bump_in;
   logic [ENTRY_W-1:0] out_entry_ff, out_entry_in;
   logic [STS_W-1:0]   out_status_ff, out_status_in;
   logic               link_we;

   logic [CW-1:0] bump_x, entry_x, count_x, depth_x, sum_x;

   always_comb begin
      bump_x  = CW'(bump_ff);
      entry_x = CW'(entry_ff);
      count_x = CW'(count_ff);
      depth_x = CW'(DEPTH);
      sum_x   = bump_x + count_x;

      head_in       = head_ff;
      bump_in       = bump_ff;
      link_we       = 1'b0;
      out_entry_in  = '0;
      out_status_in = STS_OK;

      case (act_ff)
         ACT_TAKE: begin
            if (head_ff != '0) begin
               out_entry_in = head_ff;
               head_in      = link_rd_ff;
            end else if (bump_x < depth_x) begin
               out_entry_in = bump_x[ENTRY_W-1:0];
               bump_in      = bump_ff + BW'(1);
            end else begin
               out_status_in = STS_FULL;
            end
         end
         ACT_RETURN: begin
            if (entry_ff == '0 || entry_x >= bump_x || entry_x >= depth_x) begin
               out_status_in = STS_BAD;
            end else begin
               link_we = 1'b1;
               head_in = entry_ff;
            end
         end
         ACT_RESERVE: begin
            if (count_ff == '0) begin
               out_status_in = STS_OK;
            end else if (sum_x > depth_x) begin
               out_status_in = STS_FULL;
            end else begin
               out_entry_in = bump_x[ENTRY_W-1:0];
               bump_in      = sum_x[BW-1:0];
            end
         end
         default: begin
            out_status_in = STS_OK;
         end
      endcase
   end

   // link memory: one write port, one registered read port at the head
   always_ff @(posedge clock) begin
      if (cmd.execute && link_we) begin
         link_mem[entry_ff[LAW-1:0]] <= head_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         link_rd_ff <= link_mem[head_ff[LAW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         act_ff   <= req_action;
         entry_ff <= req_entry;
         count_ff <= req_count;
      end
      if (cmd.execute) begin
         out_entry_ff  <= out_entry_in;
         out_status_ff <= out_status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         bump_ff <= BW'(1);
      end else if (cmd.execute) begin
         head_ff <= head_in;
         bump_ff <= bump_in;
      end
   end

   assign rsp_entry  = out_entry_ff;
   assign rsp_status = out_status_ff;

`ifndef NO_ASSERTIONS
   a_bump_in_range: assert property (@(posedge clock) disable iff (reset)
      (CW'(bump_ff) <= CW'(DEPTH)) && (bump_ff != '0))
      else $error("bump pointer out of range");

   a_head_below_bump: assert property (@(posedge clock) disable iff (reset)
      CW'(head_ff) < CW'(bump_ff))
      else $error("free list head beyond handed out entries");
`endif

endmodule

`default_nettype wire
